/* src/kmet_pkg.sv */
`default_nettype none

package kmet_pkg;

  localparam int MatrixRows = 4;
  localparam int MatrixCols = 14;

  localparam logic [6:0] CH_BACKSPACE = 7'd8;
  localparam logic [6:0] CH_TAB       = 7'd9;
  localparam logic [6:0] CH_ENTER     = 7'd10;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_IME   = 2'd3;

  localparam logic [2:0] TOK_NONE  = 3'd0;
  localparam logic [2:0] TOK_ESC   = 3'd1;
  localparam logic [2:0] TOK_DEL   = 3'd2;
  localparam logic [2:0] TOK_UP    = 3'd3;
  localparam logic [2:0] TOK_LEFT  = 3'd4;
  localparam logic [2:0] TOK_DOWN  = 3'd5;
  localparam logic [2:0] TOK_RIGHT = 3'd6;

  localparam logic [2:0] NAV_NONE  = 3'd0;
  localparam logic [2:0] NAV_BACK  = 3'd1;
  localparam logic [2:0] NAV_UP    = 3'd2;
  localparam logic [2:0] NAV_LEFT  = 3'd3;
  localparam logic [2:0] NAV_DOWN  = 3'd4;
  localparam logic [2:0] NAV_RIGHT = 3'd5;
  localparam logic [2:0] NAV_ENTER = 3'd6;

  // matrix cell as {row[1:0], col}
  localparam logic [5:0] CELL_FN    = {2'd2, 4'd0};
  localparam logic [5:0] CELL_SHIFT = {2'd2, 4'd1};
  localparam logic [5:0] CELL_CTRL  = {2'd3, 4'd0};
  localparam logic [5:0] CELL_OPT   = {2'd3, 4'd1};
  localparam logic [5:0] CELL_ALT   = {2'd3, 4'd2};
  localparam logic [5:0] CELL_ESC   = {2'd0, 4'd0};
  localparam logic [5:0] CELL_DEL   = {2'd0, 4'd13};
  localparam logic [5:0] CELL_UP    = {2'd2, 4'd11};
  localparam logic [5:0] CELL_LEFT  = {2'd3, 4'd10};
  localparam logic [5:0] CELL_DOWN  = {2'd3, 4'd11};
  localparam logic [5:0] CELL_RIGHT = {2'd3, 4'd12};
  localparam logic [5:0] CELL_J     = {2'd2, 4'd8};
  localparam logic [5:0] CELL_SPACE = {2'd3, 4'd13};

  localparam logic [6:0] BASE_LAYER [MatrixRows][MatrixCols] = '{
    '{7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
      7'h30, 7'h2d, 7'h3d, 7'h08},
    '{7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6f,
      7'h70, 7'h5b, 7'h5d, 7'h5c},
    '{7'h00, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b,
      7'h6c, 7'h3b, 7'h27, 7'h0a},
    '{7'h00, 7'h00, 7'h00, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e, 7'h6d,
      7'h2c, 7'h2e, 7'h2f, 7'h20}
  };

  localparam logic [6:0] UPPER_LAYER [MatrixRows][MatrixCols] = '{
    '{7'h7e, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28,
      7'h29, 7'h5f, 7'h2b, 7'h08},
    '{7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4f,
      7'h50, 7'h7b, 7'h7d, 7'h7c},
    '{7'h00, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b,
      7'h4c, 7'h3a, 7'h22, 7'h0a},
    '{7'h00, 7'h00, 7'h00, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e, 7'h4d,
      7'h3c, 7'h3e, 7'h3f, 7'h20}
  };

  typedef struct packed {
    logic [2:0] row;
    logic [3:0] col;
    logic       pressed;
  } evt_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_code;
    logic [2:0] token_code;
    logic [2:0] nav_hint;
  } res_t;

  typedef struct packed {
    logic fn;
    logic shift;
    logic ctrl;
    logic opt;
    logic alt;
  } mods_t;

endpackage

`default_nettype wire

/* src/key_matrix_event_translator.sv */
// Channel  Ports                            Payload
// in       in_valid, in_ready, in_data      evt_t (row, col, pressed)
// out      out_valid, out_ready, out_data   res_t (kind, char_code, token_code, nav_hint)
//
// One request per cycle while out_ready does not stall: input register, one pass of lookup logic, result register.
// A request moves from the input register to the result register, where out_valid rises; a stall can hold it.
// Modifier flags update when a request leaves the input register, in order.
// Releases, modifier cells, out-of-range cells and Fn with a non-token cell are consumed with no result.
// Reset (rst_n low, synchronous) empties both registers and clears all flags.
// A stalled out_ready holds the result; the input register still takes one request.
`default_nettype none

module key_matrix_event_translator
  import kmet_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire evt_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  evt_t  evt_r;
  logic  evt_vld_r;
  mods_t mods_r, mods_nxt;
  res_t  res_r, res_nxt;
  logic  out_vld_r, out_vld_nxt;

  logic       adv;
  logic       hit;
  logic       in_range;
  logic [5:0] cell_id;
  logic [6:0] ch;

  function automatic logic [2:0] arrow_nav(input logic [5:0] cl);
    logic [2:0] nav;
    unique case (cl)
      CELL_ESC:   nav = NAV_BACK;
      CELL_UP:    nav = NAV_UP;
      CELL_LEFT:  nav = NAV_LEFT;
      CELL_DOWN:  nav = NAV_DOWN;
      CELL_RIGHT: nav = NAV_RIGHT;
      default:    nav = NAV_NONE;
    endcase
    return nav;
  endfunction

  assign adv      = evt_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !evt_vld_r || adv;

  assign in_range = !evt_r.row[2] && (evt_r.col < 4'(MatrixCols));
  assign cell_id  = {evt_r.row[1:0], evt_r.col};

  always_comb begin
    ch = 7'd0;
    if (in_range) begin
      ch = mods_r.shift ? UPPER_LAYER[evt_r.row[1:0]][evt_r.col]
                        : BASE_LAYER[evt_r.row[1:0]][evt_r.col];
    end
  end

  always_comb begin
    mods_nxt = mods_r;
    res_nxt  = '0;
    hit      = 1'b0;
    if (in_range) begin
      priority if (cell_id == CELL_FN) begin
        mods_nxt.fn = evt_r.pressed;
      end else if (cell_id == CELL_SHIFT) begin
        mods_nxt.shift = evt_r.pressed;
      end else if (cell_id == CELL_CTRL) begin
        mods_nxt.ctrl = evt_r.pressed;
      end else if (cell_id == CELL_OPT) begin
        mods_nxt.opt = evt_r.pressed;
      end else if (cell_id == CELL_ALT) begin
        mods_nxt.alt = evt_r.pressed;
      end else if (!evt_r.pressed) begin
        hit = 1'b0;
      end else if (mods_r.ctrl && mods_r.alt && cell_id == CELL_DEL) begin
        hit          = 1'b1;
        res_nxt.kind = KIND_STOP;
      end else if ((mods_r.ctrl && cell_id == CELL_J) ||
                   (mods_r.opt && cell_id == CELL_SPACE)) begin
        hit          = 1'b1;
        res_nxt.kind = KIND_IME;
      end else if (mods_r.fn) begin
        res_nxt.kind = KIND_TOKEN;
        hit          = 1'b1;
        unique case (cell_id)
          CELL_ESC: begin
            res_nxt.token_code = TOK_ESC;
            res_nxt.nav_hint   = NAV_BACK;
          end
          CELL_DEL:   res_nxt.token_code = TOK_DEL;
          CELL_UP: begin
            res_nxt.token_code = TOK_UP;
            res_nxt.nav_hint   = NAV_UP;
          end
          CELL_LEFT: begin
            res_nxt.token_code = TOK_LEFT;
            res_nxt.nav_hint   = NAV_LEFT;
          end
          CELL_DOWN: begin
            res_nxt.token_code = TOK_DOWN;
            res_nxt.nav_hint   = NAV_DOWN;
          end
          CELL_RIGHT: begin
            res_nxt.token_code = TOK_RIGHT;
            res_nxt.nav_hint   = NAV_RIGHT;
          end
          default: begin
            hit     = 1'b0;
            res_nxt = '0;
          end
        endcase
      end else if (ch != 7'd0) begin
        hit          = 1'b1;
        res_nxt.kind = KIND_BYTE;
        if (mods_r.ctrl && ((ch >= 7'h61 && ch <= 7'h7a) || (ch >= 7'h41 && ch <= 7'h5a))) begin
          // control byte: letter position 1..26
          res_nxt.char_code = {2'b00, ch[4:0]};
        end else begin
          res_nxt.char_code = ch;
          if (ch == CH_ENTER) begin
            res_nxt.nav_hint = NAV_ENTER;
          end else if (!mods_r.shift) begin
            res_nxt.nav_hint = arrow_nav(cell_id);
          end
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = hit;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      mods_r    <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_ready) begin
        evt_vld_r <= in_valid;
      end
      if (adv) begin
        mods_r <= mods_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      evt_r <= in_data;
    end
    if (adv && hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mods_r))
    else $error("modifier flags changed with no request consumed");

  a_range_drop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_range |=> $stable(mods_r) && !out_valid)
    else $error("out-of-range event had an effect");

  a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_BYTE |-> out_data.char_code == 7'd0)
    else $error("char_code set on a non-byte result");

  a_tok_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.token_code != TOK_NONE) == (out_data.kind == KIND_TOKEN)))
    else $error("token_code does not match kind");

  a_mod_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_range && (cell_id == CELL_FN || cell_id == CELL_SHIFT ||
      cell_id == CELL_CTRL || cell_id == CELL_OPT || cell_id == CELL_ALT) |-> !hit)
    else $error("modifier cell produced a result");

endmodule

`default_nettype wire

/* tb/key_matrix_event_translator_tb.sv */
`timescale 1ns / 100ps

module key_matrix_event_translator_tb;
  import kmet_pkg::*;

  localparam int IdleLimit = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  evt_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  mods_t held = '0;
  res_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int hold_off_req = 0;
  int hold_off_left = 0;

  key_matrix_event_translator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic evt_t key_evt(logic [6:0] rc, logic p);
    return {rc, p};
  endfunction

  // key legend; cells 0,0 / 0,13 / 1,0 / 2,13 are handled first, and all but 0,0 are not printable
  function automatic logic [6:0] legend(logic [1:0] r, logic [3:0] c, logic sh);
    string s;
    byte b;
    if (r == 2'd0 && c == 4'd0) return sh ? 7'h7e : 7'h60;
    if (r == 2'd0 && c == 4'd13) return CH_BACKSPACE;
    if (r == 2'd1 && c == 4'd0) return CH_TAB;
    if (r == 2'd2 && c == 4'd13) return CH_ENTER;
    case ({sh, r})
      3'b000: s = ".1234567890-=.";
      3'b100: s = ".!@#$%^&*()_+.";
      3'b001: s = ".qwertyuiop[]\\";
      3'b101: s = ".QWERTYUIOP{}|";
      3'b010: s = "..asdfghjkl;'.";
      3'b110: s = "..ASDFGHJKL:\".";
      3'b011: s = "...zxcvbnm,./ ";
      default: s = "...ZXCVBNM<>? ";
    endcase
    b = s[c];
    return b[6:0];
  endfunction

  function automatic bit translate_key(evt_t e, output res_t r);
    logic [5:0] key_cell;
    logic [6:0] ch;
    r = '0;
    if (e.row >= MatrixRows || e.col >= MatrixCols) return 1'b0;
    key_cell = {e.row[1:0], e.col};
    case (key_cell)
      CELL_FN:    begin held.fn = e.pressed;    return 1'b0; end
      CELL_SHIFT: begin held.shift = e.pressed; return 1'b0; end
      CELL_CTRL:  begin held.ctrl = e.pressed;  return 1'b0; end
      CELL_OPT:   begin held.opt = e.pressed;   return 1'b0; end
      CELL_ALT:   begin held.alt = e.pressed;   return 1'b0; end
      default: ;
    endcase
    if (!e.pressed) return 1'b0;
    if (held.ctrl && held.alt && key_cell == CELL_DEL) begin
      r.kind = KIND_STOP;
      return 1'b1;
    end
    if ((held.ctrl && key_cell == CELL_J) || (held.opt && key_cell == CELL_SPACE)) begin
      r.kind = KIND_IME;
      return 1'b1;
    end
    if (held.fn) begin
      r.kind = KIND_TOKEN;
      case (key_cell)
        CELL_ESC:   begin r.token_code = TOK_ESC;   r.nav_hint = NAV_BACK;  end
        CELL_DEL:   r.token_code = TOK_DEL;
        CELL_UP:    begin r.token_code = TOK_UP;    r.nav_hint = NAV_UP;    end
        CELL_LEFT:  begin r.token_code = TOK_LEFT;  r.nav_hint = NAV_LEFT;  end
        CELL_DOWN:  begin r.token_code = TOK_DOWN;  r.nav_hint = NAV_DOWN;  end
        CELL_RIGHT: begin r.token_code = TOK_RIGHT; r.nav_hint = NAV_RIGHT; end
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    r.kind = KIND_BYTE;
    ch = legend(e.row[1:0], e.col, held.shift);
    if (held.ctrl && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) begin
      r.char_code = {2'b00, ch[4:0]};
      return 1'b1;
    end
    r.char_code = ch;
    if (ch == CH_ENTER) begin
      r.nav_hint = NAV_ENTER;
    end else if (!held.shift) begin
      case (key_cell)
        CELL_ESC:   r.nav_hint = NAV_BACK;
        CELL_UP:    r.nav_hint = NAV_UP;
        CELL_LEFT:  r.nav_hint = NAV_LEFT;
        CELL_DOWN:  r.nav_hint = NAV_DOWN;
        CELL_RIGHT: r.nav_hint = NAV_RIGHT;
        default: ;
      endcase
    end
    return 1'b1;
  endfunction

  // mostly in-range presses with random modifier activity, plus noise
  function automatic evt_t random_event();
    evt_t e;
    logic [5:0] key_cell;
    int pick;
    e.row = 3'($urandom_range(3));
    e.col = 4'($urandom_range(13));
    e.pressed = 1'b1;
    pick = $urandom_range(99);
    if (pick < 14) begin
      case ($urandom_range(4))
        0: key_cell = CELL_FN;
        1: key_cell = CELL_SHIFT;
        2: key_cell = CELL_CTRL;
        3: key_cell = CELL_OPT;
        default: key_cell = CELL_ALT;
      endcase
      e = key_evt({1'b0, key_cell}, 1'($urandom_range(1)));
    end else if (pick < 22) begin
      e.row = 3'($urandom_range(4, 7));
      e.col = 4'($urandom_range(15));
      e.pressed = 1'($urandom_range(1));
    end else if (pick < 26) begin
      e.col = 4'($urandom_range(14, 15));
      e.pressed = 1'($urandom_range(1));
    end else if (pick < 36) begin
      e.pressed = 1'b0;
    end else if (pick < 58) begin
      case ($urandom_range(9))
        0: key_cell = CELL_ESC;
        1: key_cell = CELL_DEL;
        2: key_cell = CELL_UP;
        3: key_cell = CELL_LEFT;
        4: key_cell = CELL_DOWN;
        5: key_cell = CELL_RIGHT;
        6: key_cell = CELL_J;
        7: key_cell = CELL_SPACE;
        8: key_cell = {2'd2, 4'd13};
        default: key_cell = {2'd1, 4'd0};
      endcase
      e = key_evt({1'b0, key_cell}, 1'b1);
    end
    return e;
  endfunction

  task automatic send_event(evt_t e);
    while (send_gaps && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed_keys();
    send_event(key_evt({3'd7, 4'd15}, 1'b1));
    send_event(key_evt({3'd0, 4'd14}, 1'b1));
    send_event(key_evt({1'b0, CELL_ESC}, 1'b1));
    send_event(key_evt({1'b0, CELL_DEL}, 1'b1));
    send_event(key_evt({3'd1, 4'd0}, 1'b1));
    send_event(key_evt({3'd2, 4'd13}, 1'b1));
    send_event(key_evt({1'b0, CELL_RIGHT}, 1'b1));
    send_event(key_evt({1'b0, CELL_RIGHT}, 1'b0));
    send_event(key_evt({1'b0, CELL_SHIFT}, 1'b1));
    send_event(key_evt({1'b0, CELL_DOWN}, 1'b1));
    send_event(key_evt({1'b0, CELL_FN}, 1'b1));
    send_event(key_evt({1'b0, CELL_ESC}, 1'b1));
    send_event(key_evt({1'b0, CELL_DEL}, 1'b1));
    send_event(key_evt({1'b0, CELL_UP}, 1'b1));
    send_event(key_evt({1'b0, CELL_LEFT}, 1'b1));
    send_event(key_evt({1'b0, CELL_DOWN}, 1'b1));
    send_event(key_evt({1'b0, CELL_RIGHT}, 1'b1));
    send_event(key_evt({3'd1, 4'd1}, 1'b1));
    send_event(key_evt({1'b0, CELL_FN}, 1'b0));
    send_event(key_evt({1'b0, CELL_CTRL}, 1'b1));
    send_event(key_evt({3'd3, 4'd3}, 1'b1));
    send_event(key_evt({1'b0, CELL_J}, 1'b1));
    send_event(key_evt({1'b0, CELL_ALT}, 1'b1));
    send_event(key_evt({1'b0, CELL_DEL}, 1'b1));
    send_event(key_evt({1'b0, CELL_OPT}, 1'b1));
    send_event(key_evt({1'b0, CELL_SPACE}, 1'b1));
    send_event(key_evt({1'b0, CELL_SHIFT}, 1'b0));
    send_event(key_evt({1'b0, CELL_CTRL}, 1'b0));
    send_event(key_evt({1'b0, CELL_ALT}, 1'b0));
    send_event(key_evt({1'b0, CELL_OPT}, 1'b0));
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (150) send_event(random_event());
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // receiver stalls long while presses keep coming
  task automatic test_output_stall();
    send_event(key_evt({1'b0, CELL_FN}, 1'b0));
    send_gaps = 1'b0;
    hold_off_req = 150;
    repeat (40) send_event(key_evt({3'd1, 4'($urandom_range(1, 13))}, 1'b1));
    send_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_event(random_event());
    in_valid <= 1'b0;
    wait_drained();
    repeat (20) send_event(random_event());
  endtask

  task automatic test_random_typing();
    repeat (890) send_event(random_event());
  endtask

  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_off_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_left != 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_gaps && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    res_t want;
    res_t next;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: kind %0d char %0d token %0d nav %0d",
               out_data.kind, out_data.char_code, out_data.token_code, out_data.nav_hint);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          mismatch_count++;
        end
        if (out_data.char_code !== want.char_code) begin
          $error("char_code: expected %0d, got %0d", want.char_code, out_data.char_code);
          mismatch_count++;
        end
        if (out_data.token_code !== want.token_code) begin
          $error("token_code: expected %0d, got %0d", want.token_code, out_data.token_code);
          mismatch_count++;
        end
        if (out_data.nav_hint !== want.nav_hint) begin
          $error("nav_hint: expected %0d, got %0d", want.nav_hint, out_data.nav_hint);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (translate_key(in_data, next)) pending_results.push_back(next);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("key_matrix_event_translator_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_keys();
    test_full_rate();
    test_output_stall();
    test_drain_pause();
    test_random_typing();
    in_valid <= 1'b0;
    wait_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("key_matrix_event_translator_tb: clean");
    end else begin
      $display("key_matrix_event_translator_tb: errors");
    end
    $finish;
  end

endmodule
